// File: sv/dhm_pkg.sv
// ----------------------------------------------------------------------------
// dhm_pkg: shared types and constants of the missing entry log
// Hash constants, status and mode codes, back end states, result layout.
// ----------------------------------------------------------------------------
package dhm_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [11:0] CAP_RESET = 12'd2730;

  localparam logic [31:0] HOME_MUL_A   = 32'd1363546567;
  localparam logic [31:0] HOME_MUL_B   = 32'd985732289;
  localparam logic [31:0] STRIDE_MUL_A = 32'd2345123993;
  localparam logic [31:0] STRIDE_MUL_B = 32'd746344009;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SWAP   = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_IGNORED   = 3'd2,
    STAT_SWAPPED   = 3'd3,
    STAT_READ      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_PROBE,
    BS_RDOUT
  } back_state_e;

  typedef struct packed {
    logic [2:0]  status;
    logic        entry_valid;
    logic [63:0] chunk_id;
    logic [31:0] inode;
    logic [31:0] index;
    logic [7:0]  mtype;
    logic [12:0] prev_entries;
  } result_t;

endpackage

// File: sv/dhm_fifo.sv
// ----------------------------------------------------------------------------
// dhm_fifo: small register queue
// Holds a few transactions between two sides that stall on their own.
// ----------------------------------------------------------------------------
module dhm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = dhm_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // store pushed transaction
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: sv/dhm_front.sv
// ----------------------------------------------------------------------------
// dhm_front: input stage and hash pipeline
// Accepts transactions and computes home slot and odd stride over two stages.
// ----------------------------------------------------------------------------
module dhm_front #(
  parameter int unsigned ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        mode_i,
  input  logic [63:0]       chunk_id_i,
  input  logic [31:0]       inode_number_i,
  input  logic [31:0]       chunk_index_i,
  input  logic [7:0]        missing_type_i,
  input  logic [11:0]       slot_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        mode_o,
  output logic [63:0]       chunk_id_o,
  output logic [31:0]       inode_o,
  output logic [31:0]       index_o,
  output logic [7:0]        mtype_o,
  output logic [11:0]       slot_o,
  output logic [ADDR_W-1:0] home_o,
  output logic [ADDR_W-1:0] stride_o
);
  logic        s1_v_q, s2_v_q, s1_ready, s2_ready;
  logic [1:0]  s1_mode_q, s2_mode_q;
  logic [63:0] s1_chunk_q, s2_chunk_q;
  logic [31:0] s1_inode_q, s2_inode_q, s1_idx_q, s2_idx_q;
  logic [7:0]  s1_type_q, s2_type_q;
  logic [11:0] s1_slot_q, s2_slot_q;
  logic [31:0] s1_p_q, s1_q_q, s2_p_q, s2_q_q;

  assign s2_ready = !s2_v_q || out_ready_i;
  assign s1_ready = !s1_v_q || s2_ready;
  assign full     = !s1_ready;

  // hold valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= push;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  // first multiply stage
  always_ff @(posedge clk_i) begin
    if (s1_ready && push) begin
      s1_mode_q  <= mode_i;
      s1_chunk_q <= chunk_id_i;
      s1_inode_q <= inode_number_i;
      s1_idx_q   <= chunk_index_i;
      s1_type_q  <= missing_type_i;
      s1_slot_q  <= slot_i;
      s1_p_q     <= inode_number_i * dhm_pkg::HOME_MUL_A;
      s1_q_q     <= inode_number_i * dhm_pkg::STRIDE_MUL_A;
    end
  end

  // second multiply stage
  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_mode_q  <= s1_mode_q;
      s2_chunk_q <= s1_chunk_q;
      s2_inode_q <= s1_inode_q;
      s2_idx_q   <= s1_idx_q;
      s2_type_q  <= s1_type_q;
      s2_slot_q  <= s1_slot_q;
      s2_p_q     <= (s1_p_q ^ s1_idx_q) * dhm_pkg::HOME_MUL_B;
      s2_q_q     <= (s1_q_q + s1_idx_q) * dhm_pkg::STRIDE_MUL_B;
    end
  end

  // fold in chunk id, reduce to slot count, force odd stride
  assign out_valid_o = s2_v_q;
  assign mode_o      = s2_mode_q;
  assign chunk_id_o  = s2_chunk_q;
  assign inode_o     = s2_inode_q;
  assign index_o     = s2_idx_q;
  assign mtype_o     = s2_type_q;
  assign slot_o      = s2_slot_q;
  assign home_o      = ADDR_W'(s2_p_q ^ s2_chunk_q[31:0]);
  assign stride_o    = ADDR_W'(s2_q_q + s2_chunk_q[31:0]) | ADDR_W'(1);

endmodule

// File: sv/dhm_back.sv
// ----------------------------------------------------------------------------
// dhm_back: bank memories and command sequencer
// Probes, stores, reads and clears the two banks; produces one result each.
// ----------------------------------------------------------------------------
module dhm_back #(
  parameter int unsigned TABLE_SLOTS = dhm_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned ADDR_W      = $clog2(TABLE_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [11:0]       cfg_data_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  logic [1:0]        mode_i,
  input  logic [63:0]       chunk_id_i,
  input  logic [31:0]       inode_i,
  input  logic [31:0]       index_i,
  input  logic [7:0]        mtype_i,
  input  logic [11:0]       slot_i,
  input  logic [ADDR_W-1:0] home_i,
  input  logic [ADDR_W-1:0] stride_i,
  input  logic              res_full_i,
  output logic              res_push_o,
  output dhm_pkg::result_t  res_o
);
  localparam int unsigned MEM_AW    = ADDR_W + 1;
  localparam int unsigned MEM_DEPTH = 2 * TABLE_SLOTS;

  dhm_pkg::back_state_e state_q, state_d;

  logic              bank_q, bank_d, blocked_q, blocked_d, clr_all_q, clr_all_d;
  logic [12:0]       cur_q, cur_d, prev_q, prev_d;
  logic [11:0]       cap_q, cap_d;
  logic [MEM_AW-1:0] clr_ptr_q, clr_ptr_d;
  logic [ADDR_W-1:0] pos_q, pos_d, stride_q, stride_d, probe_q, probe_d;
  logic [63:0]       ins_chunk_q;
  logic [31:0]       ins_inode_q, ins_idx_q;
  logic [7:0]        ins_type_q;
  logic              capture;

  // memories
  logic [63:0]       chunk_mem [MEM_DEPTH];
  logic [71:0]       pay_mem   [MEM_DEPTH];
  logic [63:0]       chunk_rd_q;
  logic [71:0]       pay_rd_q;
  logic              rd_en, we, pay_we;
  logic [MEM_AW-1:0] rd_addr, wr_addr;
  logic [63:0]       wr_chunk;
  logic [ADDR_W-1:0] next_pos;
  logic              refuse, hit;

  assign refuse   = blocked_q || (cur_q >= {1'b0, cap_q}) || (chunk_id_i == '0);
  assign hit      = (chunk_rd_q == ins_chunk_q) && (pay_rd_q[71:40] == ins_inode_q)
                    && (pay_rd_q[39:8] == ins_idx_q);
  assign next_pos = pos_q + stride_q;

  // next state and outputs
  always_comb begin
    state_d   = state_q;
    bank_d    = bank_q;
    blocked_d = blocked_q;
    clr_all_d = clr_all_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    cap_d     = cap_q;
    clr_ptr_d = clr_ptr_q;
    pos_d     = pos_q;
    stride_d  = stride_q;
    probe_d   = probe_q;
    capture   = 1'b0;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o     = '0;
    res_o.status = dhm_pkg::STAT_IGNORED;
    rd_en     = 1'b0;
    rd_addr   = '0;
    we        = 1'b0;
    pay_we    = 1'b0;
    wr_addr   = '0;
    wr_chunk  = '0;

    case (state_q)
      dhm_pkg::BS_CLEAR: begin
        we      = 1'b1;
        wr_addr = clr_all_q ? clr_ptr_q : {bank_q, clr_ptr_q[ADDR_W-1:0]};
        if (clr_ptr_q == (clr_all_q ? MEM_AW'(MEM_DEPTH - 1) : MEM_AW'(TABLE_SLOTS - 1)))
        begin
          state_d   = dhm_pkg::BS_IDLE;
          clr_all_d = 1'b0;
        end else begin
          clr_ptr_d = clr_ptr_q + MEM_AW'(1);
        end
      end
      dhm_pkg::BS_IDLE: begin
        if (cmd_valid_i && !res_full_i && !cfg_we_i) begin
          cmd_pop_o = 1'b1;
          case (mode_i)
            dhm_pkg::MODE_INSERT: begin
              if (refuse) begin
                res_push_o = 1'b1;
              end else begin
                rd_en    = 1'b1;
                rd_addr  = {bank_q, home_i};
                pos_d    = home_i;
                stride_d = stride_i;
                probe_d  = '0;
                capture  = 1'b1;
                state_d  = dhm_pkg::BS_PROBE;
              end
            end
            dhm_pkg::MODE_SWAP: begin
              res_push_o   = 1'b1;
              res_o.status = dhm_pkg::STAT_SWAPPED;
              if (blocked_q) begin
                blocked_d = 1'b0;
              end else begin
                bank_d    = !bank_q;
                prev_d    = cur_q;
                cur_d     = '0;
                clr_ptr_d = '0;
                state_d   = dhm_pkg::BS_CLEAR;
              end
            end
            dhm_pkg::MODE_READ: begin
              if (32'(slot_i) < 32'(TABLE_SLOTS)) begin
                rd_en   = 1'b1;
                rd_addr = {!bank_q, ADDR_W'(slot_i)};
                state_d = dhm_pkg::BS_RDOUT;
              end else begin
                res_push_o   = 1'b1;
                res_o.status = dhm_pkg::STAT_READ;
              end
            end
            default: begin
              res_push_o = 1'b1;
            end
          endcase
        end
      end
      dhm_pkg::BS_PROBE: begin
        if (chunk_rd_q == '0) begin
          we           = 1'b1;
          pay_we       = 1'b1;
          wr_addr      = {bank_q, pos_q};
          wr_chunk     = ins_chunk_q;
          cur_d        = cur_q + 13'd1;
          res_push_o   = 1'b1;
          res_o.status = dhm_pkg::STAT_INSERTED;
          state_d      = dhm_pkg::BS_IDLE;
        end else if (hit) begin
          res_push_o   = 1'b1;
          res_o.status = dhm_pkg::STAT_DUPLICATE;
          state_d      = dhm_pkg::BS_IDLE;
        end else if (probe_q == ADDR_W'(TABLE_SLOTS - 1)) begin
          res_push_o = 1'b1;
          state_d    = dhm_pkg::BS_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = {bank_q, next_pos};
          pos_d   = next_pos;
          probe_d = probe_q + ADDR_W'(1);
        end
      end
      dhm_pkg::BS_RDOUT: begin
        res_push_o   = 1'b1;
        res_o.status = dhm_pkg::STAT_READ;
        if (chunk_rd_q != '0) begin
          res_o.entry_valid = 1'b1;
          res_o.chunk_id    = chunk_rd_q;
          res_o.inode       = pay_rd_q[71:40];
          res_o.index       = pay_rd_q[39:8];
          res_o.mtype       = pay_rd_q[7:0];
        end
        state_d = dhm_pkg::BS_IDLE;
      end
      default: begin
        state_d = dhm_pkg::BS_IDLE;
      end
    endcase

    res_o.prev_entries = prev_d;

    // capacity write: clear current bank and block inserts
    if (cfg_we_i) begin
      cap_d     = cfg_data_i;
      cur_d     = '0;
      blocked_d = 1'b1;
      clr_ptr_d = '0;
      state_d   = dhm_pkg::BS_CLEAR;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dhm_pkg::BS_CLEAR;
      bank_q    <= 1'b0;
      blocked_q <= 1'b0;
      clr_all_q <= 1'b1;
      cur_q     <= '0;
      prev_q    <= '0;
      cap_q     <= dhm_pkg::CAP_RESET;
      clr_ptr_q <= '0;
      pos_q     <= '0;
      stride_q  <= '0;
      probe_q   <= '0;
    end else begin
      state_q   <= state_d;
      bank_q    <= bank_d;
      blocked_q <= blocked_d;
      clr_all_q <= clr_all_d;
      cur_q     <= cur_d;
      prev_q    <= prev_d;
      cap_q     <= cap_d;
      clr_ptr_q <= clr_ptr_d;
      pos_q     <= pos_d;
      stride_q  <= stride_d;
      probe_q   <= probe_d;
    end
  end

  // hold entry under insertion
  always_ff @(posedge clk_i) begin
    if (capture) begin
      ins_chunk_q <= chunk_id_i;
      ins_inode_q <= inode_i;
      ins_idx_q   <= index_i;
      ins_type_q  <= mtype_i;
    end
  end

  // bank memories with registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      chunk_mem[wr_addr] <= wr_chunk;
    end
    if (pay_we) begin
      pay_mem[wr_addr] <= {ins_inode_q, ins_idx_q, ins_type_q};
    end
    if (rd_en) begin
      chunk_rd_q <= chunk_mem[rd_addr];
      pay_rd_q   <= pay_mem[rd_addr];
    end
  end

  // checks
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dhm_pkg::BS_CLEAR) |-> !cmd_pop_o)
    else $error("command taken during clear pass");

  a_res_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= {1'b0, cap_q})
    else $error("entry count beyond capacity");

  a_probe_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dhm_pkg::BS_PROBE && !rd_en) |-> res_push_o)
    else $error("probe ended without a result");

endmodule

// File: sv/double_hash_missing_entry_log.sv
// ----------------------------------------------------------------------------
// double_hash_missing_entry_log: two-bank double-hashing entry set
// Front hash pipeline, command queue, bank sequencer and result queue.
// ----------------------------------------------------------------------------
// Timing: an item passes the hash pipeline stages s1 and s2 and then waits in a
// two-entry command queue for the bank sequencer, which handles one command
// at a time over a single memory read port. An insert reads its home slot
// and then probes further slots, one slot read per cycle, up to TABLE_SLOTS
// probes; a refused insert, a swap that only lifts the block, and an unknown
// mode answer in the same cycle as they are taken, and a read answers from its
// registered slot read. A swap that turns the banks starts a clearing pass
// over the new current bank, and a capacity write starts the same pass; after
// reset a pass clears both banks. No command is taken from the queue during a
// pass. Results wait in a two-entry queue, so the sequencer goes on while
// the consumer stalls, until that queue is full.
module double_hash_missing_entry_log #(
  parameter int unsigned TABLE_SLOTS = dhm_pkg::TABLE_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [63:0] chunk_id_i,
  input  logic [31:0] inode_number_i,
  input  logic [31:0] chunk_index_i,
  input  logic [7:0]  missing_type_i,
  input  logic [11:0] slot_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic        entry_valid_o,
  output logic [63:0] out_chunk_id_o,
  output logic [31:0] out_inode_o,
  output logic [31:0] out_index_o,
  output logic [7:0]  out_type_o,
  output logic [12:0] previous_entries_o
);
  localparam int unsigned ADDR_W = $clog2(TABLE_SLOTS);
  localparam int unsigned CMD_W  = 2 + 64 + 32 + 32 + 8 + 12 + 2 * ADDR_W;

  logic              f_valid, cq_full, cq_empty, cq_pop;
  logic [1:0]        f_mode, c_mode;
  logic [63:0]       f_chunk, c_chunk;
  logic [31:0]       f_inode, f_idx, c_inode, c_idx;
  logic [7:0]        f_type, c_type;
  logic [11:0]       f_slot, c_slot;
  logic [ADDR_W-1:0] f_home, f_stride, c_home, c_stride;
  logic [CMD_W-1:0]  cq_wdata, cq_rdata;

  logic              rq_full, res_push;
  dhm_pkg::result_t  res_in, res_out;

  dhm_front #(.ADDR_W(ADDR_W)) u_front (
    .clk_i, .rst_ni, .push, .full,
    .mode_i, .chunk_id_i, .inode_number_i, .chunk_index_i, .missing_type_i, .slot_i,
    .out_valid_o(f_valid), .out_ready_i(!cq_full),
    .mode_o(f_mode), .chunk_id_o(f_chunk), .inode_o(f_inode), .index_o(f_idx),
    .mtype_o(f_type), .slot_o(f_slot), .home_o(f_home), .stride_o(f_stride)
  );

  // pack command transaction
  assign cq_wdata = {f_mode, f_chunk, f_inode, f_idx, f_type, f_slot, f_home, f_stride};
  assign {c_mode, c_chunk, c_inode, c_idx, c_type, c_slot, c_home, c_stride} = cq_rdata;

  dhm_fifo #(.WIDTH(CMD_W), .DEPTH(dhm_pkg::QUEUE_DEPTH)) u_cmd_q (
    .clk_i, .rst_ni,
    .push_i(f_valid), .wdata_i(cq_wdata), .full_o(cq_full),
    .pop_i(cq_pop), .rdata_o(cq_rdata), .empty_o(cq_empty)
  );

  dhm_back #(.TABLE_SLOTS(TABLE_SLOTS), .ADDR_W(ADDR_W)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .cmd_valid_i(!cq_empty), .cmd_pop_o(cq_pop),
    .mode_i(c_mode), .chunk_id_i(c_chunk), .inode_i(c_inode), .index_i(c_idx),
    .mtype_i(c_type), .slot_i(c_slot), .home_i(c_home), .stride_i(c_stride),
    .res_full_i(rq_full), .res_push_o(res_push), .res_o(res_in)
  );

  dhm_fifo #(.WIDTH($bits(dhm_pkg::result_t)), .DEPTH(dhm_pkg::QUEUE_DEPTH)) u_res_q (
    .clk_i, .rst_ni,
    .push_i(res_push), .wdata_i(res_in), .full_o(rq_full),
    .pop_i(pop), .rdata_o(res_out), .empty_o(empty)
  );

  // unpack result transaction
  assign status_o           = res_out.status;
  assign entry_valid_o      = res_out.entry_valid;
  assign out_chunk_id_o     = res_out.chunk_id;
  assign out_inode_o        = res_out.inode;
  assign out_index_o        = res_out.index;
  assign out_type_o         = res_out.mtype;
  assign previous_entries_o = res_out.prev_entries;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for double_hash_missing_entry_log
// Drives insert, swap, read and unknown-mode transactions with random gaps on both queue
// sides, predicts each result with a local two-bank set, and compares field
// by field in order. Capacity is rewritten between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned SLOTS    = 4096;
  localparam int unsigned WD_LIMIT = 200000;

  // mode code outside the defined set
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] chunk;
    logic [31:0] inode;
    logic [31:0] index;
    logic [7:0]  mtype;
    logic [11:0] slot;
  } entry_cmd_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [11:0] cfg_data_i;
  logic        push;
  logic        full;
  logic [1:0]  mode_i;
  logic [63:0] chunk_id_i;
  logic [31:0] inode_number_i;
  logic [31:0] chunk_index_i;
  logic [7:0]  missing_type_i;
  logic [11:0] slot_i;
  logic        empty;
  logic        pop;
  logic [2:0]  status_o;
  logic        entry_valid_o;
  logic [63:0] out_chunk_id_o;
  logic [31:0] out_inode_o;
  logic [31:0] out_index_o;
  logic [7:0]  out_type_o;
  logic [12:0] previous_entries_o;

  double_hash_missing_entry_log uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .push(push), .full(full), .mode_i(mode_i), .chunk_id_i(chunk_id_i),
    .inode_number_i(inode_number_i), .chunk_index_i(chunk_index_i),
    .missing_type_i(missing_type_i), .slot_i(slot_i), .empty(empty), .pop(pop),
    .status_o(status_o), .entry_valid_o(entry_valid_o),
    .out_chunk_id_o(out_chunk_id_o), .out_inode_o(out_inode_o),
    .out_index_o(out_index_o), .out_type_o(out_type_o),
    .previous_entries_o(previous_entries_o)
  );

  // Local copy of the set state
  logic [63:0] chunk_mem [2*SLOTS];
  logic [31:0] inode_mem [2*SLOTS];
  logic [31:0] index_mem [2*SLOTS];
  logic [7:0]  type_mem  [2*SLOTS];
  logic        cur_bank;
  logic [12:0] cur_count;
  logic [12:0] prev_count;
  logic        blocked;
  logic [11:0] capacity;

  entry_cmd_t        pending_cmds[$];
  dhm_pkg::result_t  expected_results[$];
  entry_cmd_t        recent_cmds[$];
  int                error_count;
  int                idle_cycles;
  int                send_gap;
  int                recv_gap;
  bit                hold_send;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic void clear_bank(logic bank);
    for (int i = 0; i < SLOTS; i++) chunk_mem[bank*SLOTS+i] = '0;
  endfunction

  // Compute the result of one transaction and advance the local state
  function automatic dhm_pkg::result_t predict_entry_result(entry_cmd_t c);
    dhm_pkg::result_t r;
    logic [31:0] home, stride, lo;
    int pos, a;
    r = '0;
    r.status = dhm_pkg::STAT_IGNORED;
    case (c.mode)
      dhm_pkg::MODE_INSERT: begin
        if (!blocked && cur_count < capacity && c.chunk != 0) begin
          lo = c.chunk[31:0];
          home = (((c.inode * dhm_pkg::HOME_MUL_A) ^ c.index) * dhm_pkg::HOME_MUL_B) ^ lo;
          stride = (((c.inode * dhm_pkg::STRIDE_MUL_A) + c.index) * dhm_pkg::STRIDE_MUL_B)
                   + lo;
          pos = home % SLOTS;
          stride = (stride % SLOTS) | 32'd1;
          for (int n = 0; n < SLOTS; n++) begin
            a = cur_bank * SLOTS + pos;
            if (chunk_mem[a] == 0) begin
              chunk_mem[a] = c.chunk;
              inode_mem[a] = c.inode;
              index_mem[a] = c.index;
              type_mem[a] = c.mtype;
              cur_count++;
              r.status = dhm_pkg::STAT_INSERTED;
              break;
            end
            if (chunk_mem[a] == c.chunk && inode_mem[a] == c.inode &&
                index_mem[a] == c.index) begin
              r.status = dhm_pkg::STAT_DUPLICATE;
              break;
            end
            pos = (pos + stride) % SLOTS;
          end
        end
      end
      dhm_pkg::MODE_SWAP: begin
        if (blocked) begin
          blocked = 1'b0;
        end else begin
          cur_bank = ~cur_bank;
          clear_bank(cur_bank);
          prev_count = cur_count;
          cur_count = '0;
        end
        r.status = dhm_pkg::STAT_SWAPPED;
      end
      dhm_pkg::MODE_READ: begin
        r.status = dhm_pkg::STAT_READ;
        a = (cur_bank ? 0 : SLOTS) + c.slot;
        if (c.slot < SLOTS && chunk_mem[a] != 0) begin
          r.entry_valid = 1'b1;
          r.chunk_id = chunk_mem[a];
          r.inode = inode_mem[a];
          r.index = index_mem[a];
          r.mtype = type_mem[a];
        end
      end
      default: ;
    endcase
    r.prev_entries = prev_count;
    return r;
  endfunction

  function automatic entry_cmd_t rand_insert();
    entry_cmd_t c;
    c.mode = dhm_pkg::MODE_INSERT;
    c.chunk = {$urandom, $urandom};
    c.inode = $urandom;
    c.index = $urandom;
    c.mtype = 8'($urandom);
    c.slot = 12'($urandom);
    return c;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Driver: present the next pending transaction after a random gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      send_gap <= 0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(predict_entry_result(pending_cmds.pop_front()));
      end
      if (push && full) begin
        // hold the current transaction
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        push <= 1'b0;
      end else if (hold_send || pending_cmds.size() == 0) begin
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        mode_i <= pending_cmds[0].mode;
        chunk_id_i <= pending_cmds[0].chunk;
        inode_number_i <= pending_cmds[0].inode;
        chunk_index_i <= pending_cmds[0].index;
        missing_type_i <= pending_cmds[0].mtype;
        slot_i <= pending_cmds[0].slot;
        send_gap <= pick_gap();
      end
    end
  end

  // Monitor: pop with random stalls and compare against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    dhm_pkg::result_t exp_r, got;
    if (!rst_ni) begin
      pop <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (pop && !empty) begin
        got = {status_o, entry_valid_o, out_chunk_id_o, out_inode_o, out_index_o,
               out_type_o, previous_entries_o};
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            error_count++;
            if (error_count <= 10)
              $display({"mismatch: exp st=%0d v=%0d c=%h i=%h x=%h t=%h p=%0d",
                        " got st=%0d v=%0d c=%h i=%h x=%h t=%h p=%0d"},
                exp_r.status, exp_r.entry_valid, exp_r.chunk_id, exp_r.inode,
                exp_r.index, exp_r.mtype, exp_r.prev_entries, got.status,
                got.entry_valid, got.chunk_id, got.inode, got.index, got.mtype,
                got.prev_entries);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (pop && !empty) recv_gap <= pick_gap();
      end
    end
  end

  // Watchdog: count cycles without any accepted transaction
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni ||
        (pending_cmds.size() == 0 && expected_results.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Wait until every queued transaction is accepted and answered
  task automatic drain();
    while (pending_cmds.size() != 0 || push || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (3 * SLOTS) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [11:0] v);
    drain();
    hold_send = 1'b1;
    cfg_data_i <= v;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    capacity = v;
    clear_bank(cur_bank);
    cur_count = '0;
    blocked = 1'b1;
    hold_send = 1'b0;
  endtask

  // Phase of random traffic: mostly inserts, with repeats, swaps, reads and unknown modes
  task automatic random_phase(int count);
    entry_cmd_t c;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 55 || recent_cmds.size() == 0) begin
        c = rand_insert();
        if ($urandom_range(3) == 0) c.chunk = 64'($urandom_range(3));
        if ($urandom_range(4) == 0) c.chunk[63] = 1'b1;
        recent_cmds.push_back(c);
      end else if (r < 65) begin
        c = recent_cmds[$urandom_range(recent_cmds.size() - 1)];
        c.mtype = 8'($urandom);
      end else if (r < 72) begin
        c = rand_insert();
        c.mode = dhm_pkg::MODE_SWAP;
      end else if (r < 97) begin
        c = rand_insert();
        c.mode = dhm_pkg::MODE_READ;
      end else begin
        c = rand_insert();
        c.mode = MODE_UNUSED;
      end
      pending_cmds.push_back(c);
    end
  endtask

  initial begin
    entry_cmd_t c;
    logic [11:0] caps [4];
    for (int i = 0; i < 2*SLOTS; i++) begin
      chunk_mem[i] = '0;
      inode_mem[i] = '0;
      index_mem[i] = '0;
      type_mem[i] = '0;
    end
    cur_bank = 1'b0;
    cur_count = '0;
    prev_count = '0;
    blocked = 1'b0;
    capacity = dhm_pkg::CAP_RESET;
    error_count = 0;
    idle_cycles = 0;
    hold_send = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    push = 1'b0;
    pop = 1'b0;
    mode_i = '0;
    chunk_id_i = '0;
    inode_number_i = '0;
    chunk_index_i = '0;
    missing_type_i = '0;
    slot_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, duplicates, zero chunk, swap, reads, bad mode
    c = rand_insert();
    c.chunk = '1; c.inode = '1; c.index = '1; c.mtype = '1;
    pending_cmds.push_back(c);
    pending_cmds.push_back(c);
    c.chunk = 64'd1; c.inode = '0; c.index = '0; c.mtype = '0;
    pending_cmds.push_back(c);
    c.chunk = '0;
    pending_cmds.push_back(c);
    c.chunk = 64'd1; c.index = 32'd1;
    pending_cmds.push_back(c);
    c.mode = MODE_UNUSED;
    pending_cmds.push_back(c);
    c.mode = dhm_pkg::MODE_SWAP;
    pending_cmds.push_back(c);
    for (int s = 0; s < 8; s++) begin
      c = rand_insert();
      c.mode = dhm_pkg::MODE_READ;
      c.slot = (s == 0) ? 12'd0 : (s == 1) ? 12'hFFF : 12'($urandom);
      pending_cmds.push_back(c);
    end
    random_phase(100);

    // Capacity settings: small, minimum, zero, maximum
    caps[0] = 12'd5;
    caps[1] = 12'd1;
    caps[2] = 12'd0;
    caps[3] = 12'hFFF;
    for (int k = 0; k < 4; k++) begin
      write_capacity(caps[k]);
      random_phase(75);
    end
    drain();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
